@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, byte codes and echo sequence decode for the line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int MAX_LINE_DEF = 64;
  localparam int CAP_W        = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd60;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_AT    = 8'd64;
  localparam logic [7:0] CH_CARET = 8'd94;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_CARET,
    KIND_CR,
    KIND_RUB_NARROW,
    KIND_RUB_WIDE
  } echo_kind_t;

  typedef logic [2:0] echo_idx_t;

  // everything one received byte leaves for the output side
  typedef struct packed {
    echo_kind_t  kind;
    logic [7:0]  ch;
    logic        store_valid;
    logic [5:0]  store_index;
    logic [7:0]  store_byte;
    logic        line_done;
    logic [6:0]  line_length;
  } sle_bundle_t;

  function automatic echo_idx_t echo_count(input echo_kind_t kind);
    echo_idx_t n;
    n = 3'd1;
    unique case (kind)
      KIND_PLAIN:      n = 3'd1;
      KIND_CARET:      n = 3'd2;
      KIND_CR:         n = 3'd3;
      KIND_RUB_NARROW: n = 3'd3;
      KIND_RUB_WIDE:   n = 3'd6;
      default:         n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_at(input echo_kind_t kind, input logic [7:0] ch,
                                         input echo_idx_t idx);
    logic [7:0] e;
    e = ch;
    unique case (kind)
      KIND_PLAIN:      e = ch;
      KIND_CARET:      e = (idx == 3'd0) ? CH_CARET : ch;
      KIND_CR:         e = (idx == 3'd2) ? CH_LF : CH_CR;
      KIND_RUB_NARROW: e = (idx == 3'd1) ? CH_SP : CH_BS;
      KIND_RUB_WIDE:   e = (idx == 3'd2 || idx == 3'd3) ? CH_SP : CH_BS;
      default:         e = ch;
    endcase
    return e;
  endfunction

endpackage

@@ hw/rtl/sle_edit.sv @@
// ----------------------------------------------------------------------------
// sle_edit
// Write position, capacity register and control-mark store; decides the
// echo sequence and buffer write for each accepted byte.
// ----------------------------------------------------------------------------
module sle_edit #(
  parameter int MAX_LINE = sle_pkg::MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [sle_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  output logic                      bnd_valid,
  output sle_pkg::sle_bundle_t      bnd
);
  import sle_pkg::*;

  localparam int PW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int CW = (PW + 1 > CAP_W) ? PW + 1 : CAP_W;

  logic [PW-1:0]    wp_r, wp_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             prev_mark_r;
  logic             marks [MAX_LINE];

  logic          is_bs, at_zero, full, done, mark;
  logic [CW-1:0] pos_ext, pos1, cap_ext, cap_eff;
  logic [7:0]    sbyte;

  always_comb begin
    is_bs   = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    at_zero = (wp_r == '0);
    pos_ext = CW'(wp_r);
    pos1    = pos_ext + CW'(1);
    cap_ext = CW'(cap_r);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(MAX_LINE)) begin
      cap_eff = CW'(MAX_LINE);
    end else begin
      cap_eff = cap_ext;
    end
    full  = (pos1 >= cap_eff);
    sbyte = (rx_byte == CH_CR) ? CH_LF : rx_byte;
    mark  = (sbyte < CH_SP);
    done  = (rx_byte == CH_CR) || full;

    bnd             = '0;
    bnd.ch          = rx_byte;
    bnd_valid       = 1'b1;
    if (is_bs) begin
      bnd_valid = !at_zero;
      bnd.kind  = prev_mark_r ? KIND_RUB_WIDE : KIND_RUB_NARROW;
    end else begin
      if (rx_byte == CH_CR) begin
        bnd.kind = KIND_CR;
      end else if (rx_byte == CH_NUL) begin
        bnd.kind = KIND_CARET;
        bnd.ch   = CH_ZERO;
      end else if (rx_byte < CH_SP) begin
        // 28 lands on backslash here as well
        bnd.kind = KIND_CARET;
        bnd.ch   = CH_AT + rx_byte;
      end else begin
        bnd.kind = KIND_PLAIN;
      end
      bnd.store_valid = 1'b1;
      bnd.store_index = pos_ext[5:0];
      bnd.store_byte  = sbyte;
      bnd.line_done   = done;
      bnd.line_length = done ? pos1[6:0] : 7'd0;
    end

    wp_nxt = wp_r;
    if (accept) begin
      if (is_bs) begin
        if (!at_zero) begin
          wp_nxt = wp_r - PW'(1);
        end
      end else if (done) begin
        wp_nxt = '0;
      end else begin
        wp_nxt = wp_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      cap_r <= CAP_RESET;
    end else begin
      wp_r <= wp_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // mark of the position just below the write position, kept ready
  always_ff @(posedge clk) begin
    if (accept && !is_bs) begin
      marks[wp_r] <= mark;
    end
    if (accept && !(is_bs && at_zero)) begin
      prev_mark_r <= is_bs ? marks[wp_r - PW'(2)] : mark;
    end
  end

endmodule

@@ hw/rtl/sle_emit.sv @@
// ----------------------------------------------------------------------------
// sle_emit
// Holds one byte's result bundle and sends its echo beats one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module sle_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sle_pkg::sle_bundle_t bnd_in,
  output logic                 load_ok,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_echo_valid,
  output logic [7:0]           out_echo_byte,
  output logic                 out_store_valid,
  output logic [5:0]           out_store_index,
  output logic [7:0]           out_store_byte,
  output logic                 out_line_done,
  output logic [6:0]           out_line_length,
  output logic                 out_last
);
  import sle_pkg::*;

  logic        busy_r, busy_nxt;
  sle_bundle_t bnd_r;
  echo_idx_t   idx_r, idx_nxt;
  logic        fin, take;

  always_comb begin
    fin     = (idx_r == echo_count(bnd_r.kind) - 3'd1);
    take    = busy_r && !out_stall;
    load_ok = !busy_r || (take && fin);

    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (take) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bnd_r <= bnd_in;
    end
  end

  // store and line fields ride only on the final beat
  assign out_valid       = busy_r;
  assign out_echo_valid  = 1'b1;
  assign out_echo_byte   = echo_at(bnd_r.kind, bnd_r.ch, idx_r);
  assign out_store_valid = fin & bnd_r.store_valid;
  assign out_store_index = fin ? bnd_r.store_index : 6'd0;
  assign out_store_byte  = fin ? bnd_r.store_byte : 8'd0;
  assign out_line_done   = fin & bnd_r.line_done;
  assign out_line_length = fin ? bnd_r.line_length : 7'd0;
  assign out_last        = fin;

endmodule

@@ hw/rtl/serial_line_editor_echo_core.sv @@
// Timing: the first echo beat appears in the cycle after the byte is accepted.
// Throughput: one echo beat per cycle while out_stall is low; each byte gives
// 1 to 6 echo beats, and the next byte is taken on the last beat of the one
// before; a backspace at line start is accepted and gives no beat.
// Reset: write position to 0, capacity to 60, output stage empty.
// ----------------------------------------------------------------------------
// serial_line_editor_echo_core
// Console line editor with terminal echo and line buffer writes.
// ----------------------------------------------------------------------------
module serial_line_editor_echo_core #(
  parameter int MAX_LINE = sle_pkg::MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [sle_pkg::CAP_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_echo_valid,
  output logic [7:0]                out_echo_byte,
  output logic                      out_store_valid,
  output logic [5:0]                out_store_index,
  output logic [7:0]                out_store_byte,
  output logic                      out_line_done,
  output logic [6:0]                out_line_length,
  output logic                      out_last
);
  import sle_pkg::*;

  logic        accept, load_ok, bnd_valid;
  sle_bundle_t bnd;

  assign in_stall = !load_ok;
  assign accept   = in_valid && load_ok;

  sle_edit #(
    .MAX_LINE(MAX_LINE)
  ) u_edit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .rx_byte    (in_rx_byte),
    .bnd_valid  (bnd_valid),
    .bnd        (bnd)
  );

  sle_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept && bnd_valid),
    .bnd_in         (bnd),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_echo_valid (out_echo_valid),
    .out_echo_byte  (out_echo_byte),
    .out_store_valid(out_store_valid),
    .out_store_index(out_store_index),
    .out_store_byte (out_store_byte),
    .out_line_done  (out_line_done),
    .out_line_length(out_line_length),
    .out_last       (out_last)
  );

endmodule
